/* hw/rtl/smaller_predecessor_sum_unit_macros.svh */
// Assertion macros shared by the smaller predecessor sum unit.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef SMALLER_PREDECESSOR_SUM_UNIT_MACROS_SVH
`define SMALLER_PREDECESSOR_SUM_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define SPSU_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("spsu assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define SPSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spsu assertion failed");
`else
`define SPSU_ASSERT_ALWAYS(lbl, cond)
`define SPSU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/spsu_pkg.sv */
package spsu_pkg;

    localparam int CONTRIB_BITS = 36;
    localparam int TOTAL_BITS   = 51;

    // Control flags that ride along with a word through the cell chain.
    typedef struct packed {
        logic valid;
        logic last;
        logic placed;   // word already stored in some cell
    } t_tok_ctl;

    function automatic logic [CONTRIB_BITS-1:0] sat_contrib(
        input logic [CONTRIB_BITS:0] sum
    );
        logic [CONTRIB_BITS-1:0] res;
        res = sum[CONTRIB_BITS] ? {CONTRIB_BITS{1'b1}} : sum[CONTRIB_BITS-1:0];
        return res;
    endfunction

    function automatic logic [TOTAL_BITS-1:0] sat_total(
        input logic [TOTAL_BITS:0] sum
    );
        logic [TOTAL_BITS-1:0] res;
        res = sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];
        return res;
    endfunction

endpackage

/* hw/rtl/spsu_cell.sv */
`include "smaller_predecessor_sum_unit_macros.svh"

module spsu_cell
    import spsu_pkg::*;
#(
    parameter int VALUE_BITS = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  t_tok_ctl                i_ctl,
    input  logic [VALUE_BITS-1:0]   i_value,
    input  logic [CONTRIB_BITS-1:0] i_sum,
    output t_tok_ctl                o_ctl,
    output logic [VALUE_BITS-1:0]   o_value,
    output logic [CONTRIB_BITS-1:0] o_sum
);

    logic                    r_held;
    logic [VALUE_BITS-1:0]   r_stored;
    t_tok_ctl                r_ctl;
    logic [VALUE_BITS-1:0]   r_value;
    logic [CONTRIB_BITS-1:0] r_sum;

    logic                    n_held;
    logic                    store_here;
    logic [CONTRIB_BITS-1:0] n_sum;
    t_tok_ctl                n_ctl;

    // Stored value counts only if strictly smaller than the passing word.
    always_comb begin
        store_here = i_ctl.valid && !r_held && !i_ctl.placed;
        n_ctl      = i_ctl;
        n_held     = r_held;
        if (i_ctl.valid && r_held && (r_stored < i_value)) begin
            n_sum = sat_contrib({1'b0, i_sum} +
                                {{(CONTRIB_BITS + 1 - VALUE_BITS){1'b0}}, r_stored});
        end else begin
            n_sum = i_sum;
        end
        if (store_here) begin
            n_ctl.placed = 1'b1;
            n_held       = !i_ctl.last;
        end else if (i_ctl.valid && i_ctl.last) begin
            n_held = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
            r_ctl  <= '0;
        end else if (i_adv) begin
            r_held <= n_held;
            r_ctl  <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_value <= i_value;
            r_sum   <= n_sum;
            if (store_here) begin
                r_stored <= i_value;
            end
        end
    end

    assign o_ctl   = r_ctl;
    assign o_value = r_value;
    assign o_sum   = r_sum;

    `SPSU_ASSERT_NEXT(a_last_clears, i_adv && i_ctl.valid && i_ctl.last, !r_held)
    `SPSU_ASSERT_NEXT(a_empty_places, i_adv && i_ctl.valid && !r_held, r_ctl.placed)

endmodule

/* hw/rtl/spsu_tally.sv */
`include "smaller_predecessor_sum_unit_macros.svh"

module spsu_tally
    import spsu_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  t_tok_ctl                i_ctl,
    input  logic [CONTRIB_BITS-1:0] i_sum,
    output logic                    o_valid,
    output logic [CONTRIB_BITS-1:0] o_contribution,
    output logic [TOTAL_BITS-1:0]   o_running_total,
    output logic                    o_is_final,
    output logic                    o_overflow
);

    logic                    r_valid;
    logic [TOTAL_BITS-1:0]   r_acc;
    logic [CONTRIB_BITS-1:0] r_contrib;
    logic [TOTAL_BITS-1:0]   r_total;
    logic                    r_final;
    logic                    r_ovf;
    logic [TOTAL_BITS-1:0]   n_total;

    assign n_total = sat_total({1'b0, r_acc} +
                               {{(TOTAL_BITS + 1 - CONTRIB_BITS){1'b0}}, i_sum});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
        end else if (i_adv) begin
            r_valid <= i_ctl.valid;
            if (i_ctl.valid) begin
                r_acc <= i_ctl.last ? '0 : n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_ctl.valid) begin
            r_contrib <= i_sum;
            r_total   <= n_total;
            r_final   <= i_ctl.last;
            r_ovf     <= !i_ctl.placed;
        end
    end

    assign o_valid         = r_valid;
    assign o_contribution  = r_contrib;
    assign o_running_total = r_total;
    assign o_is_final      = r_final;
    assign o_overflow      = r_ovf;

    `SPSU_ASSERT_NEXT(a_acc_cleared, i_adv && i_ctl.valid && i_ctl.last, r_acc == '0)
    `SPSU_ASSERT_ALWAYS(a_total_covers,
        !r_valid || ({{(TOTAL_BITS - CONTRIB_BITS){1'b0}}, r_contrib} <= r_total))

endmodule

/* hw/rtl/smaller_predecessor_sum_unit.sv */
// Path: a word passes each cell in turn (one register per cell), then the
//   tally/output register.
// Throughput: one word per cycle; the whole chain and output register move together,
//   so a stalled output holds every cell in place.
// Reset (synchronous, active low): empties every cell, drops all words in flight,
//   clears the running total. No clearing pass is needed.
module smaller_predecessor_sum_unit
    import spsu_pkg::*;
#(
    parameter int MAX_ITEMS  = 1024,
    parameter int VALUE_BITS = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [VALUE_BITS-1:0]   i_value,
    input  logic                    i_last_of_set,
    // result channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [CONTRIB_BITS-1:0] o_contribution,
    output logic [TOTAL_BITS-1:0]   o_running_total,
    output logic                    o_is_final,
    output logic                    o_overflow
);

    // Each cell holds at most one stored value of the current sequence. A word
    // walks the chain comparing against every stored value and accumulating
    // the smaller ones; the first empty cell it meets keeps its value. Cells
    // fill front to back, so a word that reaches the end still unplaced found
    // the store full and is flagged as overflow. A word marked last empties
    // every cell behind it, so the next sequence starts from a clean chain.
    // Words follow each other in order, so each one sees exactly the values
    // its predecessors left.

    t_tok_ctl                chain_ctl   [MAX_ITEMS+1];
    logic [VALUE_BITS-1:0]   chain_value [MAX_ITEMS+1];
    logic [CONTRIB_BITS-1:0] chain_sum   [MAX_ITEMS+1];

    logic adv;

    // Everything advances unless the result register is full and not taken.
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    assign chain_ctl[0]   = '{valid: i_valid, last: i_last_of_set, placed: 1'b0};
    assign chain_value[0] = i_value;
    assign chain_sum[0]   = '0;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        spsu_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_ctl   (chain_ctl[g]),
            .i_value (chain_value[g]),
            .i_sum   (chain_sum[g]),
            .o_ctl   (chain_ctl[g+1]),
            .o_value (chain_value[g+1]),
            .o_sum   (chain_sum[g+1])
        );
    end

    // The value has served its purpose once it leaves the last cell.
    spsu_tally u_tally (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_ctl           (chain_ctl[MAX_ITEMS]),
        .i_sum           (chain_sum[MAX_ITEMS]),
        .o_valid         (o_valid),
        .o_contribution  (o_contribution),
        .o_running_total (o_running_total),
        .o_is_final      (o_is_final),
        .o_overflow      (o_overflow)
    );

endmodule

/* test/smaller_predecessor_sum_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the unit, keeps its own copy of the set store and
// compares every result word with the oldest predicted one.
module smaller_predecessor_sum_checker
    import spsu_pkg::*;
#(
    parameter int MAX_ITEMS  = 1024,
    parameter int VALUE_BITS = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [VALUE_BITS-1:0]   i_value,
    input  logic                    i_last_of_set,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [CONTRIB_BITS-1:0] i_contribution,
    input  logic [TOTAL_BITS-1:0]   i_running_total,
    input  logic                    i_is_final,
    input  logic                    i_overflow,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked,
    output int                      o_overflows
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CONTRIB_BITS-1:0] contribution;
        logic [TOTAL_BITS-1:0]   running_total;
        logic                    is_final;
        logic                    overflow;
    } t_sum_word;

    logic [VALUE_BITS-1:0] set_values [MAX_ITEMS];
    int                    set_count = 0;
    logic [TOTAL_BITS-1:0] set_total = '0;
    t_sum_word             sums_due [$];

    // Sum of stored values strictly below the new one, then store it if there
    // is room; a closing word empties the set.
    function automatic t_sum_word next_sum(
        input logic [VALUE_BITS-1:0] value,
        input logic                  last
    );
        t_sum_word             res;
        logic [CONTRIB_BITS:0] acc;
        logic [TOTAL_BITS:0]   tot;
        int                    k;
        acc = '0;
        for (k = 0; k < set_count; k++) begin
            if (set_values[k] < value) begin
                acc = acc + {{(CONTRIB_BITS + 1 - VALUE_BITS){1'b0}}, set_values[k]};
                if (acc[CONTRIB_BITS]) acc = {1'b0, {CONTRIB_BITS{1'b1}}};
            end
        end
        tot = {1'b0, set_total} +
              {{(TOTAL_BITS + 1 - CONTRIB_BITS){1'b0}}, acc[CONTRIB_BITS-1:0]};
        if (tot[TOTAL_BITS]) tot = {1'b0, {TOTAL_BITS{1'b1}}};
        set_total = tot[TOTAL_BITS-1:0];
        res.contribution  = acc[CONTRIB_BITS-1:0];
        res.running_total = set_total;
        res.is_final      = last;
        res.overflow      = (set_count >= MAX_ITEMS);
        if (!res.overflow) begin
            set_values[set_count] = value;
            set_count++;
        end
        if (last) begin
            set_count = 0;
            set_total = '0;
        end
        return res;
    endfunction

    // Pairs are expected/actual.
    task automatic log_failure(input string why, input t_sum_word exp, input t_sum_word got);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT) begin
            $display("%0t %s: contrib %0d/%0d total %0d/%0d final %0b/%0b ovf %0b/%0b",
                     $time, why, exp.contribution, got.contribution,
                     exp.running_total, got.running_total,
                     exp.is_final, got.is_final, exp.overflow, got.overflow);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_sum_word got;
        if (!i_rst_n) begin
            sums_due.delete();
            set_count = 0;
            set_total = '0;
        end else begin
            // Pop before push: a word accepted at this edge cannot leave at it.
            if (i_out_valid && i_out_ready) begin
                got = {i_contribution, i_running_total, i_is_final, i_overflow};
                o_checked++;
                if (i_overflow) o_overflows++;
                if (sums_due.size() == 0) begin
                    log_failure("unexpected result", '0, got);
                end else if (got !== sums_due[0]) begin
                    log_failure("mismatch", sums_due[0], got);
                    void'(sums_due.pop_front());
                end else begin
                    void'(sums_due.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) sums_due.push_back(next_sum(i_value, i_last_of_set));
        end
        o_pending = sums_due.size();
    end

endmodule

/* test/tb_smaller_predecessor_sum_unit.sv */
`timescale 1ns / 1ps

module tb_smaller_predecessor_sum_unit;
    import spsu_pkg::*;

    localparam int MAX_ITEMS    = 1024;
    localparam int VALUE_BITS   = 20;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
    // A word passes every cell, then the output register.
    localparam int PIPE_DEPTH   = MAX_ITEMS + 1;
    // About 1100 words in all: the directed sets, the one long set that
    // overruns the store, and random short sets for the rest.
    localparam int ITEM_BUDGET  = 1100;
    localparam int SHORT_BUDGET = ITEM_BUDGET - MAX_ITEMS - 20;
    // Slowest legal run stays well inside this limit (every word behind a
    // full sender gap and a receiver stall, plus a handful of pipe drains).
    localparam int CYCLE_LIMIT  = 600000;

    // How the values of one set are drawn.
    typedef enum int {
        VALS_FULL,      // anywhere in range
        VALS_TINY,      // 0..7, lots of equal values
        VALS_HIGH,      // crowded just below the maximum
        VALS_ONEHOT     // a single bit set
    } t_value_style;

    // Receiver behavior; each lasts a random stretch of cycles.
    typedef enum int {
        SINK_OPEN,      // always ready
        SINK_LIGHT,     // stalls now and then
        SINK_HEAVY,     // mostly stalled; sink_stall caps a run of stalls
        SINK_COMB       // ready whenever sink_phase is a multiple of four
    } t_sink_pattern;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                    src_valid = 1'b0;
    logic                    src_ready;
    logic [VALUE_BITS-1:0]   src_value = '0;
    logic                    src_last  = 1'b0;
    logic                    res_valid;
    logic                    res_ready = 1'b0;
    logic [CONTRIB_BITS-1:0] res_contribution;
    logic [TOTAL_BITS-1:0]   res_running_total;
    logic                    res_is_final;
    logic                    res_overflow;

    int fail_count;
    int pending;
    int checked;
    int overflows;

    int cycle_count  = 0;
    int burst_left   = 0;
    bit sender_calm  = 1'b0;
    int words_sent   = 0;
    int sets_sent    = 0;
    int long_set_len = 0;

    smaller_predecessor_sum_unit #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (src_valid),
        .o_ready         (src_ready),
        .i_value         (src_value),
        .i_last_of_set   (src_last),
        .o_valid         (res_valid),
        .i_ready         (res_ready),
        .o_contribution  (res_contribution),
        .o_running_total (res_running_total),
        .o_is_final      (res_is_final),
        .o_overflow      (res_overflow)
    );

    smaller_predecessor_sum_checker #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (src_valid),
        .i_in_ready      (src_ready),
        .i_value         (src_value),
        .i_last_of_set   (src_last),
        .i_out_valid     (res_valid),
        .i_out_ready     (res_ready),
        .i_contribution  (res_contribution),
        .i_running_total (res_running_total),
        .i_is_final      (res_is_final),
        .i_overflow      (res_overflow),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_overflows     (overflows)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Receiver: switches between stall patterns after a random stretch, so
    // that stalls land on every phase of the cell chain.
    t_sink_pattern sink_mode  = SINK_OPEN;
    int            sink_left  = 0;
    int            sink_stall = 0;
    int            sink_phase = 0;

    always @(negedge clk) begin : sink_pace
        logic take;
        if (sink_left == 0) begin
            sink_mode = t_sink_pattern'($urandom_range(0, 3));
            sink_left = $urandom_range(40, 300);
        end
        sink_left--;
        case (sink_mode)
            SINK_OPEN:  take = 1'b1;
            SINK_LIGHT: take = ($urandom_range(0, 3) != 0);
            SINK_HEAVY: take = (sink_stall >= 6) || ($urandom_range(0, 3) == 0);
            default:    take = (sink_phase % 4 == 0);
        endcase
        sink_stall = take ? 0 : sink_stall + 1;
        sink_phase++;
        res_ready <= take;
    end

    // One word on the input channel. Valid goes up at a falling edge and stays
    // up, payload frozen, until a rising edge sees ready. Gaps fall only
    // between bursts, and not at all while the sender is calm.
    task automatic send_word(input logic [VALUE_BITS-1:0] value, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap        = sender_calm ? 0 : $urandom_range(0, 12);
            burst_left = $urandom_range(1, 24);
            repeat (gap) begin
                @(negedge clk);
                src_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        src_valid <= 1'b1;
        src_value <= value;
        src_last  <= last;
        do @(posedge clk); while (!src_ready);
        words_sent++;
        if (last) sets_sent++;
    endtask

    // Hold the sender off until every result word has come back.
    task automatic drain_results();
        @(negedge clk);
        src_valid <= 1'b0;
        wait (pending == 0);
        burst_left = 0;
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_value(input t_value_style style);
        case (style)
            VALS_TINY:   return VALUE_BITS'($urandom_range(0, 7));
            VALS_HIGH:   return VALUE_MAX - VALUE_BITS'($urandom_range(0, 15));
            VALS_ONEHOT: return VALUE_BITS'(1 << $urandom_range(0, VALUE_BITS - 1));
            default:     return VALUE_BITS'($urandom_range(0, VALUE_MAX));
        endcase
    endfunction

    // A whole set; now and then a word strays from the set's style so that
    // small and huge values meet in one set.
    task automatic send_set(input int len, input t_value_style style);
        t_value_style pick;
        for (int n = 0; n < len; n++) begin
            pick = ($urandom_range(0, 7) == 0) ? t_value_style'($urandom_range(0, 3)) : style;
            send_word(pick_value(pick), n == len - 1);
        end
    endtask

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int           short_words;
        int           len;
        bit           long_done;
        t_value_style style;

        short_words = 0;
        long_done   = 1'b0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed sets. First: zero and maximum values, equal values that
        // must add nothing, and a closing word that sums all smaller ones.
        send_word(20'd0, 1'b0);
        send_word(VALUE_MAX, 1'b0);
        send_word(VALUE_MAX, 1'b0);
        send_word(20'd5, 1'b0);
        send_word(20'd5, 1'b0);
        send_word(20'd7, 1'b0);
        send_word(20'd3, 1'b0);
        send_word(VALUE_MAX, 1'b1);
        // A set of one word, right behind a closing word.
        send_word(20'd12345, 1'b1);
        // Alternating bit patterns, then all ones.
        send_word(20'hAAAAA, 1'b0);
        send_word(20'h55555, 1'b0);
        send_word(VALUE_MAX, 1'b1);
        // Rising set: every word adds all before it.
        send_word(20'd1, 1'b0);
        send_word(20'd2, 1'b0);
        send_word(20'd3, 1'b0);
        send_word(20'd4, 1'b1);
        // Falling set: nothing ever adds.
        send_word(20'd4, 1'b0);
        send_word(20'd3, 1'b0);
        send_word(20'd2, 1'b0);
        send_word(20'd1, 1'b1);

        // Let the pipe run empty once before the random part.
        drain_results();

        // Random sets, mostly short. Halfway through comes one set longer
        // than the store, so its tail words hit the full store and report
        // overflow, with the exact-fit word just before them.
        while (short_words < SHORT_BUDGET) begin
            len         = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                      : $urandom_range(1, 16);
            style       = t_value_style'($urandom_range(0, 3));
            sender_calm = ($urandom_range(0, 4) == 0);
            send_set(len, style);
            short_words += len;
            if ($urandom_range(0, 29) == 0) drain_results();
            if (!long_done && short_words >= SHORT_BUDGET / 2) begin
                long_set_len = MAX_ITEMS + $urandom_range(2, 8);
                sender_calm  = 1'b0;
                send_set(long_set_len, VALS_FULL);
                drain_results();
                long_done = 1'b1;
            end
        end

        @(negedge clk);
        src_valid <= 1'b0;
        wait (pending == 0);
        // Room for any stray word still inside the chain.
        repeat (PIPE_DEPTH + 16) @(posedge clk);

        $display("sent %0d words in %0d sets, one set of %0d words on a %0d-entry store",
                 words_sent, sets_sent, long_set_len, MAX_ITEMS);
        $display("checked %0d result words, %0d with overflow set, %0d failures",
                 checked, overflows, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
